// ===== src/lnss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnss_pkg
// Shared types, constants and the frame builder for the LCD nibble serializer.
// ----------------------------------------------------------------------------
package lnss_pkg;

  localparam int unsigned FrameBits  = 8;
  localparam int unsigned FrameCount = 5;
  localparam int unsigned StreamBits = FrameBits * FrameCount;
  localparam int unsigned CountWidth = $clog2(StreamBits + 1);

  // Shift register output bit positions and masks
  localparam logic [7:0] EnableBit  = 8'b0000_1000;
  localparam logic [7:0] SelectBit  = 8'b0000_0100;
  localparam logic [7:0] HighNibble = 8'hf0;
  localparam logic [7:0] EnableClr  = 8'b1111_0111;

  // Contents of one cell of the chain
  typedef struct packed {
    logic serial_bit;
    logic latch_after;
    logic last;
  } beat_t;

  // Build the five frames of one write; the first bit on the wire is the MSB.
  function automatic logic [StreamBits-1:0] build_stream(input logic       action,
                                                          input logic [7:0] value);
    logic [7:0] sel;
    logic [7:0] f0;
    logic [7:0] f1;
    logic [7:0] f2;
    logic [7:0] f3;
    logic [7:0] f4;
    sel = action ? SelectBit : 8'h00;
    f0  = EnableBit | sel;
    f1  = f0 | (value & HighNibble);
    f2  = f1 & EnableClr;
    f3  = EnableBit | sel | {value[3:0], 4'b0000};
    f4  = f3 & EnableClr;
    return {f0, f1, f2, f3, f4};
  endfunction

endpackage

// ===== src/lcd_nibble_shift_serializer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_nibble_shift_serializer_unit
// Serial bit stream for a 595-driven character LCD in 4-bit mode.
// ----------------------------------------------------------------------------
// Each input item is one LCD write (tuser = 1 for data, 0 for a command;
// tdata = the byte). The block turns it into five 8-bit frames for the shift
// register, all carrying the select level (enable alone, enable with high
// nibble, high nibble with enable cleared, enable with low nibble, low nibble
// with enable cleared) and sends them MSB first, one output item per bit:
// tdata[0] is the data pin level, tuser marks the eighth bit of a frame (pulse
// the latch after it) and tlast marks the final bit of the write. A write is
// 40 bits: the stream leaves through one head cell at one bit per cycle while
// tready is high. The next write is loaded in the same cycle the final bit is
// taken, so writes follow with no gap. Output items hold while tready is low.
// ----------------------------------------------------------------------------
module lcd_nibble_shift_serializer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] value
  input  logic       s_axis_tuser,   // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] serial_bit, [7:1] zero
  output logic       m_axis_tuser,   // [0] latch_after
  output logic       m_axis_tlast    // last
);

  localparam int unsigned Bits = lnss_pkg::StreamBits;
  localparam int unsigned CntW = lnss_pkg::CountWidth;

  // Bits of the current write still in the chain, head included
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;

  logic            load;
  logic            advance;
  logic [Bits-1:0] stream;

  lnss_pkg::beat_t beats    [Bits];
  lnss_pkg::beat_t load_beats[Bits];

  assign advance       = m_axis_tvalid & m_axis_tready;
  // Take a new write when empty or when the final bit leaves this cycle
  assign s_axis_tready = (cnt_q == '0) || ((cnt_q == CntW'(1)) && m_axis_tready);
  assign load          = s_axis_tvalid & s_axis_tready;
  assign stream        = lnss_pkg::build_stream(s_axis_tuser, s_axis_tdata);

  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = CntW'(Bits);
    end else if (advance) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Chain of cells: cell 0 is the head, each cell but the tail takes its upper neighbor, the tail takes zeros
  for (genvar i = 0; i < Bits; i++) begin : g_cell
    lnss_pkg::beat_t next_beat;

    assign load_beats[i].serial_bit  = stream[Bits-1-i];
    assign load_beats[i].latch_after = ((i % lnss_pkg::FrameBits) ==
                                        (lnss_pkg::FrameBits - 1));
    assign load_beats[i].last        = (i == (Bits - 1));

    if (i == Bits - 1) begin : g_tail
      assign next_beat = '0;
    end else begin : g_body
      assign next_beat = beats[i+1];
    end

    lnss_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (load),
      .shift_i     (advance),
      .load_beat_i (load_beats[i]),
      .shift_beat_i(next_beat),
      .beat_o      (beats[i])
    );
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {7'b0, beats[0].serial_bit};
  assign m_axis_tuser  = beats[0].latch_after;
  assign m_axis_tlast  = beats[0].last;

  // Never more bits outstanding than one write holds
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Bits))
    else $error("bit count beyond one write");

  // A load fills the whole chain
  a_load_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (cnt_q == CntW'(Bits)))
    else $error("chain not full after load");

  // Final-bit flag reaches the head exactly when one bit remains
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (cnt_q == CntW'(1))))
    else $error("tlast out of place");

  // The head of a full chain is the first frame bit: neither latch nor final flag set
  a_first_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(Bits)) |-> (!m_axis_tuser && !m_axis_tlast))
    else $error("flags set on first bit of a write");

endmodule

// ===== src/lnss_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnss_cell
// One stage of the serializer chain: load a beat or take the neighbor's beat.
// ----------------------------------------------------------------------------
module lnss_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            shift_i,
  input  lnss_pkg::beat_t load_beat_i,
  input  lnss_pkg::beat_t shift_beat_i,
  output lnss_pkg::beat_t beat_o
);

  lnss_pkg::beat_t beat_q;
  lnss_pkg::beat_t beat_d;

  always_comb begin
    beat_d = beat_q;
    if (load_i) begin
      beat_d = load_beat_i;
    end else if (shift_i) begin
      beat_d = shift_beat_i;
    end
  end

  // Payload only: no reset needed
  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign beat_o = beat_q;

endmodule
